// ----- design/hsl2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// HSL to RGB converter package
// Field layout, hue constants, reciprocal constants and the hue ramp factor.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

  parameter int FRAC_BITS_DEF = 12;

  parameter int HUE_W     = 16;
  parameter int FRAC_IN_W = 13;
  parameter int BYTE_W    = 8;

  parameter int SAT_LSB   = HUE_W;
  parameter int LIGHT_LSB = SAT_LSB + FRAC_IN_W;
  parameter int ALPHA_LSB = LIGHT_LSB + FRAC_IN_W;
  parameter int IN_BITS   = ALPHA_LSB + FRAC_IN_W;
  parameter int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  parameter int OUT_DATA_W = 4 * BYTE_W;

  parameter int HUE_TURN       = 5760;
  parameter int HUE_SIXTH      = 960;
  parameter int HUE_THIRD      = 1920;
  parameter int HUE_HALF       = 2880;
  parameter int HUE_TWO_THIRDS = 3840;

  // (hue + 2^15) + HUE_BIAS is hue plus six full turns
  parameter int HUE_BIAS  = 1792;
  parameter int HUE_X_W   = 17;
  parameter int HUE_T_W   = 13;
  // floor(y / 45) for y < 526, and floor(y / 15) for y < 4096, as (y * R) >> 16
  parameter int HUE_RECIP  = 1457;
  parameter int BYTE_RECIP = 4370;

  parameter int FACTOR_W = 10;

  function automatic logic [FACTOR_W-1:0] ramp_factor(input logic [HUE_T_W-1:0] t);
    logic [FACTOR_W-1:0] f;
    if (t < HUE_T_W'(HUE_SIXTH)) begin
      f = t[FACTOR_W-1:0];
    end else if (t < HUE_T_W'(HUE_HALF)) begin
      f = FACTOR_W'(HUE_SIXTH);
    end else if (t < HUE_T_W'(HUE_TWO_THIRDS)) begin
      f = FACTOR_W'(HUE_T_W'(HUE_TWO_THIRDS) - t);
    end else begin
      f = '0;
    end
    return f;
  endfunction

endpackage

// ----- design/hsl_to_rgb_converter_top.sv -----
// ----------------------------------------------------------------------------
// HSL to RGB converter
// Seven-stage pipeline: hue wrap, p/q rule, per-channel ramp, byte rounding.
// ----------------------------------------------------------------------------
// Takes one color request per clock and returns its red, green, blue and alpha
// bytes once it has passed all seven register stages. The stages each hold a valid bit
// and stall on their own, so a bubble is filled while the output waits;
// s_tready follows m_tready combinationally through the stage enables.
// Throughput is one request per cycle for as long as m_tready is high.
module hsl_to_rgb_converter_top #(
  parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // hue_in[15:0], saturation_in[28:16], lightness_in[41:29], alpha_in[54:42]
  input  logic [hsl2rgb_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // red_out[7:0], green_out[15:8], blue_out[23:16], alpha_out[31:24]
  output logic [hsl2rgb_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam int F   = FRAC_BITS;
  localparam int FW  = F + 1;
  localparam int IW  = hsl2rgb_pkg::FRAC_IN_W;
  localparam int EW  = (IW > FW) ? IW : FW;
  localparam int PW  = 2 * F + 2;
  localparam int QW  = 2 * F + 1;
  localparam int NW  = 2 * F + 10;
  localparam int MW  = NW + 9;
  localparam int SH  = 2 * F;
  localparam int AW  = F + 10;
  localparam int XW  = hsl2rgb_pkg::HUE_X_W;
  localparam int TW  = hsl2rgb_pkg::HUE_T_W;
  localparam int KW  = hsl2rgb_pkg::FACTOR_W;
  localparam int BW  = hsl2rgb_pkg::BYTE_W;
  localparam int NST = 7;

  localparam logic [EW-1:0] ONE_E = EW'(1) << F;

  logic [NST:1]   v;
  logic [NST+1:1] en;

  always_comb begin
    en[NST+1] = m_tready;
    for (int k = NST; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= s_tvalid;
      end
      for (int k = 2; k <= NST; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign s_tready = en[1];
  assign m_tvalid = v[NST];

  // stage 1: bias hue, clamp fractions
  logic [EW-1:0] s_ext, l_ext, a_ext;
  logic [XW-1:0] x_in;
  logic [XW-1:0] x1;
  logic [FW-1:0] s1, l1, a1;

  always_comb begin
    s_ext = EW'(s_tdata[hsl2rgb_pkg::SAT_LSB +: IW]);
    l_ext = EW'(s_tdata[hsl2rgb_pkg::LIGHT_LSB +: IW]);
    a_ext = EW'(s_tdata[hsl2rgb_pkg::ALPHA_LSB +: IW]);
    x_in  = XW'({~s_tdata[hsl2rgb_pkg::HUE_W-1], s_tdata[hsl2rgb_pkg::HUE_W-2:0]})
          + XW'(hsl2rgb_pkg::HUE_BIAS);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x1 <= x_in;
      s1 <= (s_ext > ONE_E) ? FW'(ONE_E) : FW'(s_ext);
      l1 <= (l_ext > ONE_E) ? FW'(ONE_E) : FW'(l_ext);
      a1 <= (a_ext > ONE_E) ? FW'(ONE_E) : FW'(a_ext);
    end
  end

  // stage 2: turn count, l*s, alpha byte
  logic [20:0]   hq_prod;
  logic [AW-1:0] a_sum;
  logic [XW-1:0] x2;
  logic [3:0]    qh2;
  logic [PW-1:0] ls2;
  logic [FW-1:0] s2, l2;
  logic [BW-1:0] ab2, ab3, ab4, ab5, ab6;

  always_comb begin
    hq_prod = 21'(x1[XW-1:7]) * 21'(hsl2rgb_pkg::HUE_RECIP);
    a_sum   = AW'(a1) * AW'(510) + (AW'(1) << F);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      x2  <= x1;
      qh2 <= hq_prod[19:16];
      ls2 <= PW'(l1) * PW'(s1);
      s2  <= s1;
      l2  <= l1;
      ab2 <= a_sum[F+8:F+1];
    end
  end

  // stage 3: wrapped hue, q
  logic [XW-1:0] h_full;
  logic [PW-1:0] q_lo, q_hi;
  logic          l_low;
  logic [TW-1:0] h3;
  logic [QW-1:0] q3;
  logic [FW-1:0] l3;

  always_comb begin
    h_full = x2 - XW'(qh2) * XW'(hsl2rgb_pkg::HUE_TURN);
    l_low  = ((F + 2)'(l2) << 1) < ((F + 2)'(1) << F);
    q_lo   = (PW'(l2) << F) + ls2;
    q_hi   = ((PW'(l2) + PW'(s2)) << F) - ls2;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      h3  <= h_full[TW-1:0];
      q3  <= l_low ? QW'(q_lo) : QW'(q_hi);
      l3  <= l2;
      ab3 <= ab2;
    end
  end

  // stage 4: p, q - p, channel ramp factors
  logic [PW-1:0] p_full;
  logic [TW:0]   t_r_raw, t_b_raw;
  logic [TW-1:0] t_r, t_b;
  logic [QW-1:0] p4, d4;
  logic [KW-1:0] f4 [3];

  always_comb begin
    p_full  = (PW'(l3) << (F + 1)) - PW'(q3);
    t_r_raw = (TW + 1)'(h3) + (TW + 1)'(hsl2rgb_pkg::HUE_THIRD);
    t_b_raw = (TW + 1)'(h3) + (TW + 1)'(hsl2rgb_pkg::HUE_TWO_THIRDS);
    t_r = (t_r_raw >= (TW + 1)'(hsl2rgb_pkg::HUE_TURN)) ?
          TW'(t_r_raw - (TW + 1)'(hsl2rgb_pkg::HUE_TURN)) : t_r_raw[TW-1:0];
    t_b = (t_b_raw >= (TW + 1)'(hsl2rgb_pkg::HUE_TURN)) ?
          TW'(t_b_raw - (TW + 1)'(hsl2rgb_pkg::HUE_TURN)) : t_b_raw[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      p4    <= QW'(p_full);
      d4    <= q3 - QW'(p_full);
      f4[0] <= hsl2rgb_pkg::ramp_factor(t_r);
      f4[1] <= hsl2rgb_pkg::ramp_factor(h3);
      f4[2] <= hsl2rgb_pkg::ramp_factor(t_b);
      ab4   <= ab3;
    end
  end

  // stage 5: channel numerators scaled by one sixth turn times one squared
  logic [NW-1:0] n5 [3];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int c = 0; c < 3; c++) begin
        n5[c] <= NW'(p4) * NW'(hsl2rgb_pkg::HUE_SIXTH) + NW'(d4) * NW'(f4[c]);
      end
      ab5 <= ab4;
    end
  end

  // stage 6: times 510, drop the fraction, add half of the divisor
  logic [MW-1:0] m_full [3];
  logic [18:0]   y_full [3];
  logic [11:0]   y6     [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      m_full[c] = (MW'(n5[c]) << 9) - (MW'(n5[c]) << 1);
      y_full[c] = 19'(m_full[c] >> SH) + 19'(hsl2rgb_pkg::HUE_SIXTH);
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int c = 0; c < 3; c++) begin
        y6[c] <= y_full[c][18:7];
      end
      ab6 <= ab5;
    end
  end

  // stage 7: divide by fifteen, clamp
  logic [24:0]   b_prod [3];
  logic [BW:0]   b_raw  [3];
  logic [BW-1:0] b7     [3];
  logic [BW-1:0] ab7;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      b_prod[c] = 25'(y6[c]) * 25'(hsl2rgb_pkg::BYTE_RECIP);
      b_raw[c]  = b_prod[c][24:16];
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int c = 0; c < 3; c++) begin
        b7[c] <= (b_raw[c] > (BW + 1)'(255)) ? BW'(255) : b_raw[c][BW-1:0];
      end
      ab7 <= ab6;
    end
  end

  assign m_tdata = {ab7, b7[2], b7[1], b7[0]};

`ifndef ASSERT_OFF
  a_ready_has_room: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!(&v) || m_tready))
    else $error("input taken with a full, stalled pipeline");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> v[1])
    else $error("accepted request missing from first stage");

  a_hue_wrapped: assert property (@(posedge clk) disable iff (rst)
    v[3] |-> (h3 < TW'(hsl2rgb_pkg::HUE_TURN)))
    else $error("hue not wrapped into one turn");

  a_q_bounded: assert property (@(posedge clk) disable iff (rst)
    v[3] |-> (q3 <= (QW'(1) << SH)))
    else $error("q above one");
`endif

endmodule

// ----- tb/sv/hsl_rgb_checker.sv -----
// ----------------------------------------------------------------------------
// HSL to RGB converter checker
// Watches both stream channels and computes the expected bytes for every
// accepted color request with exact integer math. It compares each returned
// word channel by channel against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module hsl_rgb_checker
  import hsl2rgb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  // hue_in[15:0], saturation_in[28:16], lightness_in[41:29], alpha_in[54:42]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  // red_out[7:0], green_out[15:8], blue_out[23:16], alpha_out[31:24]
  input  logic [OUT_DATA_W-1:0] m_tdata,
  output int                    error_count,
  output int                    colors_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned UNIT = 64'd1 << FRAC_BITS_DEF;
  localparam int SLOT_BITS = 6;
  localparam int SLOTS     = 1 << SLOT_BITS;

  logic [OUT_DATA_W-1:0] expected_rgba[SLOTS];
  logic [SLOT_BITS-1:0]  wr_slot = '0;
  logic [SLOT_BITS-1:0]  rd_slot = '0;
  int                    held = 0;
  string                 channel_name[4] = '{"red", "green", "blue", "alpha"};

  function automatic longint unsigned clamp_unit(input logic [FRAC_IN_W-1:0] v);
    longint unsigned x;
    x = v;
    return (x > UNIT) ? UNIT : x;
  endfunction

  function automatic logic [BYTE_W-1:0] round_byte(input longint unsigned num,
                                                   input longint unsigned den);
    longint unsigned r;
    r = (num * 510 + den) / (2 * den);
    return (r > 255) ? 8'hFF : r[BYTE_W-1:0];
  endfunction

  function automatic longint unsigned ramp_level(input longint unsigned p,
                                                 input longint unsigned q,
                                                 input int t);
    longint unsigned tt;
    longint unsigned sixth;
    tt = t;
    sixth = HUE_SIXTH;
    if (t < HUE_SIXTH) begin
      return p * sixth + (q - p) * tt;
    end else if (t < HUE_HALF) begin
      return q * sixth;
    end else if (t < HUE_TWO_THIRDS) begin
      return p * sixth + (q - p) * (HUE_TWO_THIRDS - tt);
    end
    return p * sixth;
  endfunction

  function automatic logic [OUT_DATA_W-1:0] predict_rgba(input logic [IN_DATA_W-1:0] req);
    logic signed [HUE_W-1:0] hue_raw;
    int                      hue_wrap;
    longint unsigned         sat, light, alpha, q, p, den;
    logic [BYTE_W-1:0]       red, green, blue;
    hue_raw = req[HUE_W-1:0];
    hue_wrap = int'(hue_raw) % HUE_TURN;
    if (hue_wrap < 0) begin
      hue_wrap += HUE_TURN;
    end
    sat   = clamp_unit(req[SAT_LSB +: FRAC_IN_W]);
    light = clamp_unit(req[LIGHT_LSB +: FRAC_IN_W]);
    alpha = clamp_unit(req[ALPHA_LSB +: FRAC_IN_W]);
    den   = UNIT * UNIT * HUE_SIXTH;
    if (sat == 0) begin
      red   = round_byte(light, UNIT);
      green = red;
      blue  = red;
    end else begin
      if (2 * light < UNIT) begin
        q = light * (UNIT + sat);
      end else begin
        q = (light + sat) * UNIT - light * sat;
      end
      p = 2 * light * UNIT - q;
      red   = round_byte(ramp_level(p, q, (hue_wrap + HUE_THIRD) % HUE_TURN), den);
      green = round_byte(ramp_level(p, q, hue_wrap), den);
      blue  = round_byte(ramp_level(p, q, (hue_wrap + HUE_TURN - HUE_THIRD) % HUE_TURN), den);
    end
    return {round_byte(alpha, UNIT), blue, green, red};
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    error_count++;
  endtask

  always @(posedge clk) begin : watch
    logic [OUT_DATA_W-1:0] want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (held == 0) begin
          report_mismatch($sformatf("result 0x%08h with no request outstanding", m_tdata));
        end else begin
          want = expected_rgba[rd_slot];
          rd_slot = rd_slot + 1'b1;
          held--;
          for (int k = 0; k < 4; k++) begin
            if (m_tdata[k*BYTE_W +: BYTE_W] != want[k*BYTE_W +: BYTE_W]) begin
              report_mismatch($sformatf("%s got %0d expected %0d", channel_name[k],
                                        m_tdata[k*BYTE_W +: BYTE_W],
                                        want[k*BYTE_W +: BYTE_W]));
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (held == SLOTS) begin
          report_mismatch("too many requests outstanding");
        end else begin
          expected_rgba[wr_slot] = predict_rgba(s_tdata);
          wr_slot = wr_slot + 1'b1;
          held++;
        end
      end
    end
    colors_pending <= held;
  end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// HSL to RGB converter testbench
// Drives directed and random color requests into the converter with random
// gaps on both sides and one long output stall. The checker beside the block
// predicts and compares; this module reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hsl2rgb_pkg::*;

  localparam int FRAC_ONE        = 1 << FRAC_BITS_DEF;
  localparam int FRAC_MAX        = (1 << FRAC_IN_W) - 1;
  localparam int RANDOM_COLORS   = 530;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int DRAIN_CYCLES    = 20;
  localparam int CYCLE_LIMIT     = 200000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  int                    error_count;
  int                    colors_pending;
  int                    cycle_count = 0;
  bit                    hold_off_req = 1'b0;

  hsl_to_rgb_converter_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  hsl_rgb_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .error_count    (error_count),
    .colors_pending (colors_pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  function automatic int pick_fraction();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return FRAC_ONE;
      2: return $urandom_range(FRAC_ONE + 1, FRAC_MAX);
      default: return $urandom_range(0, FRAC_ONE);
    endcase
  endfunction

  task automatic send_color(input int hue, input int sat, input int light, input int alpha,
                            input int idle);
    logic [IN_DATA_W-1:0] word;
    word = '0;
    word[HUE_W-1:0]             = hue[HUE_W-1:0];
    word[SAT_LSB +: FRAC_IN_W]   = sat[FRAC_IN_W-1:0];
    word[LIGHT_LSB +: FRAC_IN_W] = light[FRAC_IN_W-1:0];
    word[ALPHA_LSB +: FRAC_IN_W] = alpha[FRAC_IN_W-1:0];
    if (idle > 0) begin
      s_tvalid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
  endtask

  initial begin : sink_side
    int run_len, stall_len;
    wait (!rst);
    forever begin
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        m_tready <= 1'b1;
        run_len = $urandom_range(1, 40);
        repeat (run_len) @(posedge clk);
        stall_len = pick_idle();
        if (stall_len > 0) begin
          m_tready <= 1'b0;
          repeat (stall_len) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int hue, gap, steady_left;
    steady_left = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_color(0, FRAC_ONE, 2048, FRAC_ONE, 0);
    send_color(HUE_THIRD, FRAC_ONE, 2048, FRAC_ONE, 0);
    send_color(HUE_TWO_THIRDS, FRAC_ONE, 2048, FRAC_ONE, pick_idle());
    send_color(-32768, FRAC_ONE, 2048, 0, pick_idle());
    send_color(32767, FRAC_ONE, 2048, FRAC_MAX, pick_idle());
    send_color(-1, 2000, 1000, 1, pick_idle());
    send_color(HUE_TURN, FRAC_ONE, 2047, 4095, pick_idle());
    send_color(-HUE_TURN, FRAC_ONE + 1, 2048, FRAC_ONE + 1, pick_idle());
    send_color(HUE_SIXTH, 3000, 3000, 2048, pick_idle());
    send_color(HUE_SIXTH - 1, 3000, 1000, 2047, pick_idle());
    send_color(HUE_HALF, FRAC_ONE, FRAC_ONE, FRAC_ONE, pick_idle());
    send_color(HUE_HALF - 1, 1, FRAC_ONE, 0, pick_idle());
    send_color(4799, FRAC_MAX, 0, FRAC_MAX, pick_idle());
    send_color(4800, FRAC_ONE, 1, 100, pick_idle());
    send_color(100, 0, 2048, FRAC_ONE, pick_idle());
    send_color(200, 0, 0, 0, pick_idle());
    send_color(300, 0, FRAC_ONE, FRAC_ONE, pick_idle());
    send_color(1000, 0, FRAC_MAX, 2049, pick_idle());
    send_color(HUE_TURN - 1, FRAC_ONE, FRAC_MAX, FRAC_ONE, pick_idle());
    send_color(HUE_TWO_THIRDS - 1, 2048, 6000, 3000, pick_idle());
    send_color(1234, FRAC_MAX, FRAC_MAX, FRAC_MAX, pick_idle());
    send_color(-12345, 7, 4095, FRAC_ONE, pick_idle());

    for (int n = 0; n < RANDOM_COLORS; n++) begin
      if (n == RANDOM_COLORS / 2) begin
        hold_off_req = 1'b1;
        steady_left = 60;
      end else if (steady_left == 0 && $urandom_range(0, 49) == 0) begin
        steady_left = $urandom_range(10, 40);
      end
      gap = (steady_left > 0) ? 0 : pick_idle();
      if (steady_left > 0) begin
        steady_left--;
      end
      case ($urandom_range(0, 4))
        0, 1: hue = $urandom_range(0, 65535);
        2: hue = $urandom_range(0, HUE_TURN - 1);
        default: hue = HUE_SIXTH * $urandom_range(0, 5) + HUE_TURN * $urandom_range(0, 9)
                       - 5 * HUE_TURN + $urandom_range(0, 4) - 2;
      endcase
      send_color(hue, pick_fraction(), pick_fraction(), pick_fraction(), gap);
    end
    s_tvalid <= 1'b0;

    do @(posedge clk); while (colors_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && colors_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- hsl_to_rgb_converter_top.f -----
design/hsl2rgb_pkg.sv
design/hsl_to_rgb_converter_top.sv
tb/sv/hsl_rgb_checker.sv
tb/sv/testbench.sv
